// ----- design/itc_pkg.sv -----
// Shared types and constants for the three-counter interval timer.
// Used by the controller, the datapath and the top level.
package itc_pkg;
  localparam int NUM_COUNTERS = 3;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;
  localparam logic [1:0] PORT_CONTROL = 2'd3;

  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  localparam logic [2:0] MODE_ONESHOT    = 3'd0;
  localparam logic [2:0] MODE_SQUARE     = 3'd3;
  localparam logic [2:0] MODE_SQUARE_ALT = 3'd7;

  typedef struct packed {
    logic       start;    // capture the item and do writes and reads
    logic       div_start;// begin ticks % reload for one counter
    logic       adv;      // apply the advance to one counter
    logic [1:0] sel;      // counter for div_start and adv
  } itc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_adv;
  } itc_stat_t;
endpackage

// ----- design/itc_ctrl.sv -----
// Controller state machine for the interval timer.
// Depends on itc_pkg; sequences the datapath per item.
module itc_ctrl import itc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  output logic      busy,
  output logic      done,
  input  itc_stat_t stat,
  output itc_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_DIV_GO, S_DIV_WAIT, S_APPLY, S_DONE} state_t;
  state_t state;
  logic [1:0] sel;

  always_comb begin
    cmd = '0;
    cmd.sel = sel;
    cmd.start = in_fire;
    cmd.div_start = (state == S_DIV_GO);
    cmd.adv = (state == S_APPLY);
  end
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_DISPATCH;
        S_DISPATCH: begin
          sel <= '0;
          state <= stat.is_adv ? S_DIV_GO : S_DONE;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: if (stat.div_done) state <= S_APPLY;
        S_APPLY: begin
          if (sel == 2'(NUM_COUNTERS - 1)) state <= S_DONE;
          else begin
            sel <= sel + 2'd1;
            state <= S_DIV_GO;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/itc_div.sv -----
// Restoring serial divider giving ticks modulo reload, one bit a cycle.
// Depends on itc_pkg only for the import style.
module itc_div import itc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic [15:0] rem,
  output logic        done
);
  logic [15:0] quo;
  logic [16:0] acc;
  logic [4:0]  cnt;
  logic        run;
  logic [16:0] trial;

  assign trial = {acc[15:0], quo[15]} - {1'b0, divisor};
  assign rem = acc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd16;
        quo <= dividend;
        acc <= '0;
      end else if (run) begin
        if (!trial[16]) acc <= trial;
        else acc <= {acc[15:0], quo[15]};
        quo <= {quo[14:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/itc_dp.sv -----
// Datapath of the interval timer: per-counter state, bus access and advance.
// Depends on itc_pkg and instantiates itc_div.
module itc_dp import itc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  itc_cmd_t    cmd,
  output itc_stat_t   stat,
  input  logic [1:0]  func,
  input  logic [1:0]  port,
  input  logic [7:0]  write_data,
  input  logic [15:0] ticks,
  output logic [7:0]  read_data,
  output logic [2:0]  outs
);
  logic [15:0] cntv [NUM_COUNTERS];
  logic [15:0] rld  [NUM_COUNTERS];
  logic [15:0] lat  [NUM_COUNTERS];
  logic [2:0]  md   [NUM_COUNTERS];
  logic [1:0]  acc  [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] run, rhi, whi, lh, lvl;
  logic [15:0] t_q;
  logic [15:0] r;
  logic [15:0] sum;
  logic [15:0] nc;
  logic [15:0] src;

  assign stat.is_adv = (func == FUNC_ADVANCE);

  itc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(t_q), .divisor(rld[cmd.sel]),
    .rem(r), .done(stat.div_done)
  );

  always_comb begin
    outs = 3'b111;
    for (int i = 0; i < NUM_COUNTERS; i++) outs[i] = lvl[i];
  end

  assign sum = cntv[cmd.sel] + rld[cmd.sel] - r;
  assign nc = (cntv[cmd.sel] < r) ? sum : cntv[cmd.sel] - r;
  assign src = lh[port] ? lat[port] : cntv[port];

  always_ff @(posedge clk) begin
    logic [1:0] c;
    logic [1:0] a;
    logic [2:0] m;
    logic [15:0] nr;
    logic        go;
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cntv[i] <= '0; rld[i] <= '0; lat[i] <= '0; md[i] <= '0; acc[i] <= ACC_LATCH;
      end
      run <= '0; rhi <= '0; whi <= '0; lh <= '0; lvl <= '1;
      read_data <= '0;
      t_q <= '0;
    end else if (cmd.start) begin
      t_q <= ticks;
      read_data <= '0;
      c = write_data[7:6];
      a = write_data[5:4];
      m = write_data[3:1];
      if (m == MODE_SQUARE_ALT) m = MODE_SQUARE;
      if (func == FUNC_WRITE && port == PORT_CONTROL) begin
        if (c < 2'(NUM_COUNTERS)) begin
          if (a == ACC_LATCH) begin
            lat[c] <= cntv[c]; lh[c] <= 1'b1; rhi[c] <= 1'b0;
          end else begin
            md[c] <= m; acc[c] <= a; lh[c] <= 1'b0; run[c] <= 1'b0;
            whi[c] <= (a == ACC_HIGH); rhi[c] <= 1'b0;
            cntv[c] <= '0; rld[c] <= '0;
            if (m == MODE_ONESHOT) lvl[c] <= 1'b0;
          end
        end
      end else if (func == FUNC_WRITE && port < 2'(NUM_COUNTERS)) begin
        go = 1'b1;
        if (!whi[port]) begin
          nr = {rld[port][15:8], write_data};
          if (acc[port] == ACC_BOTH) begin
            whi[port] <= 1'b1;
            go = 1'b0;
            if (md[port] == MODE_ONESHOT) begin
              run[port] <= 1'b0; lvl[port] <= 1'b1;
            end
          end
        end else begin
          nr = {write_data, rld[port][7:0]};
          if (acc[port] == ACC_BOTH) whi[port] <= 1'b0;
        end
        rld[port] <= nr;
        if (go && (!run[port] || md[port] == MODE_ONESHOT)) begin
          run[port] <= 1'b1;
          cntv[port] <= nr;
          if (md[port] == MODE_SQUARE) lvl[port] <= 1'b1;
          else if (md[port] == MODE_ONESHOT) lvl[port] <= 1'b0;
        end
      end else if (func == FUNC_READ) begin
        if (port == PORT_CONTROL) read_data <= 8'hFF;
        else if (port < 2'(NUM_COUNTERS)) begin
          if (!rhi[port]) begin
            rhi[port] <= 1'b1; read_data <= src[7:0];
          end else begin
            rhi[port] <= 1'b0; lh[port] <= 1'b0; read_data <= src[15:8];
          end
        end
      end
    end else if (cmd.adv && cmd.sel < 2'(NUM_COUNTERS)) begin
      if (run[cmd.sel] && md[cmd.sel] == MODE_ONESHOT) begin
        if (cntv[cmd.sel] < t_q) begin
          lvl[cmd.sel] <= 1'b1; run[cmd.sel] <= 1'b0;
        end
        cntv[cmd.sel] <= cntv[cmd.sel] - t_q;
      end else if (run[cmd.sel] && md[cmd.sel] == MODE_SQUARE) begin
        if (rld[cmd.sel] >= 16'd3) begin
          cntv[cmd.sel] <= nc;
          lvl[cmd.sel] <= !(nc < (rld[cmd.sel] >> 1));
        end
      end else begin
        cntv[cmd.sel] <= cntv[cmd.sel] - t_q;
      end
    end
  end
endmodule

// ----- design/interval_timer_three_counter_core.sv -----
// Top level of the three-counter interval timer.
// Depends on itc_pkg, itc_ctrl, itc_dp (and itc_div through it).

// One beat in gives one beat out. A bus write or read passes through the
// dispatch and done states; a time advance runs a serial remainder divider
// once per counter, one counter after another. The divider is the one
// shared unit. A finished result waits in the output register, and no new
// beat is accepted until it is taken.
module interval_timer_three_counter_core import itc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // func[1:0], port[3:2], write_data[11:4], ticks[27:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // read_data[7:0], out0[8], out1[9], out2[10]
);
  logic busy, done, in_fire;
  itc_cmd_t  cmd;
  itc_stat_t stat;
  logic [7:0] rd;
  logic [2:0] outs;

  // The controller stays idle until the output register is free.
  assign s_tready = !busy && !m_tvalid;
  assign in_fire = s_tvalid && s_tready;

  itc_ctrl u_ctrl (.clk(clk), .rst(rst), .in_fire(in_fire), .busy(busy), .done(done),
                   .stat(stat), .cmd(cmd));

  logic [1:0] f_q, p_q;
  logic [7:0] w_q;
  logic [15:0] t_q;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_q <= s_tdata[1:0]; p_q <= s_tdata[3:2];
      w_q <= s_tdata[11:4]; t_q <= s_tdata[27:12];
    end
  end

  itc_dp u_dp (.clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
               .func(in_fire ? s_tdata[1:0] : f_q),
               .port(in_fire ? s_tdata[3:2] : p_q),
               .write_data(in_fire ? s_tdata[11:4] : w_q),
               .ticks(in_fire ? s_tdata[27:12] : t_q),
               .read_data(rd), .outs(outs));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (done) m_tdata <= {5'd0, outs, rd};
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("accept while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> m_tvalid) else $error("result lost");
  a_fire_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("item not started");
endmodule

// ----- sim/tb_top.sv -----
// Testbench for interval_timer_three_counter_core: bus writes, reads and time advances
// are checked beat by beat against a behavioral model of the three counters.
// Depends on itc_pkg and the design files.
`timescale 1ns / 100ps

module tb_top;
  import itc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // func[1:0], port[3:2], write_data[11:4], ticks[27:12]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // read_data[7:0], out0[8], out1[9], out2[10]

  typedef struct packed {
    logic [7:0] rdata;
    logic [2:0] outs;
  } timer_result_t;

  interval_timer_three_counter_core dut (.*);

  always #6 clk = ~clk;

  // Timer model state.
  logic [15:0] cnt [3];
  logic [15:0] rld [3];
  logic [15:0] lat [3];
  logic [2:0]  mde [3];
  logic [1:0]  acc [3];
  logic        run [3];
  logic        rhi [3];
  logic        whi [3];
  logic        held [3];
  logic        lvl [3];

  timer_result_t expected_q[$];
  int  mismatches = 0;
  longint cycles = 0;
  int  stall = 0;

  task automatic timer_model_reset();
    for (int c = 0; c < 3; c++) begin
      cnt[c] = '0; rld[c] = '0; lat[c] = '0; mde[c] = '0; acc[c] = ACC_LATCH;
      run[c] = 1'b0; rhi[c] = 1'b0; whi[c] = 1'b0; held[c] = 1'b0; lvl[c] = 1'b1;
    end
  endtask

  function automatic void restart_count(int c);
    cnt[c] = rld[c];
    if (mde[c] == MODE_SQUARE) lvl[c] = 1'b1;
    else if (mde[c] == MODE_ONESHOT) lvl[c] = 1'b0;
  endfunction

  function automatic timer_result_t timer_predict(logic [1:0] func, logic [1:0] port,
                                                  logic [7:0] wd, logic [15:0] ticks);
    timer_result_t r;
    int c;
    logic [1:0] a;
    logic [2:0] m;
    logic [15:0] src;
    int unsigned rl, rem, cv;
    r.rdata = '0;
    c = port;
    if (func == FUNC_WRITE && port == PORT_CONTROL) begin
      c = wd[7:6];
      a = wd[5:4];
      m = wd[3:1];
      if (c < NUM_COUNTERS) begin
        if (m == MODE_SQUARE_ALT) m = MODE_SQUARE;
        if (a == ACC_LATCH) begin
          lat[c] = cnt[c]; held[c] = 1'b1; rhi[c] = 1'b0;
        end else begin
          mde[c] = m; acc[c] = a; held[c] = 1'b0; run[c] = 1'b0;
          whi[c] = (a == ACC_HIGH); rhi[c] = 1'b0; cnt[c] = '0; rld[c] = '0;
          if (m == MODE_ONESHOT) lvl[c] = 1'b0;
        end
      end
    end else if (func == FUNC_WRITE) begin
      if (!whi[c]) begin
        rld[c][7:0] = wd;
        if (acc[c] == ACC_BOTH) begin
          whi[c] = 1'b1;
          if (mde[c] == MODE_ONESHOT) begin
            run[c] = 1'b0; lvl[c] = 1'b1;
          end
          return timer_pack(r);
        end
      end else begin
        rld[c][15:8] = wd;
        if (acc[c] == ACC_BOTH) whi[c] = 1'b0;
      end
      if (!run[c] || mde[c] == MODE_ONESHOT) begin
        run[c] = 1'b1; restart_count(c);
      end
    end else if (func == FUNC_READ) begin
      if (port == PORT_CONTROL) r.rdata = 8'hFF;
      else begin
        src = held[c] ? lat[c] : cnt[c];
        if (!rhi[c]) begin
          rhi[c] = 1'b1; r.rdata = src[7:0];
        end else begin
          rhi[c] = 1'b0; held[c] = 1'b0; r.rdata = src[15:8];
        end
      end
    end else if (func == FUNC_ADVANCE) begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        cv = cnt[k];
        if (run[k] && mde[k] == MODE_ONESHOT) begin
          if (cv < ticks) begin lvl[k] = 1'b1; run[k] = 1'b0; end
          cnt[k] = cnt[k] - ticks;
        end else if (run[k] && mde[k] == MODE_SQUARE) begin
          rl = rld[k];
          if (rl >= 3) begin
            rem = ticks % rl;
            cnt[k] = (cv < rem) ? 16'(cv + rl - rem) : 16'(cv - rem);
            lvl[k] = (cnt[k] < rl / 2) ? 1'b0 : 1'b1;
          end
        end else begin
          cnt[k] = cnt[k] - ticks;
        end
      end
    end
    return timer_pack(r);
  endfunction

  function automatic timer_result_t timer_pack(timer_result_t r);
    r.outs = {lvl[2], lvl[1], lvl[0]};
    return r;
  endfunction

  // The valid line stays high between back-to-back beats and drops only for a gap or while results are drained.
  task automatic send_beat(logic [1:0] func, logic [1:0] port, logic [7:0] wd,
                           logic [15:0] ticks);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ticks, wd, port, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(timer_predict(func, port, wd, ticks));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls: mostly short, now and then a long one.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (stall > 0) begin
      m_tready <= 1'b0;
      stall <= stall - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      m_tready <= 1'b0;
      stall <= $urandom_range(10, 50);
    end else if ($urandom_range(0, 15) == 0) m_tready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (m_tdata[7:0] !== exp_r.rdata || m_tdata[10:8] !== exp_r.outs ||
            m_tdata[15:11] !== 5'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rdata %h outs %b, got rdata %h outs %b",
                     exp_r.rdata, exp_r.outs, m_tdata[7:0], m_tdata[10:8]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("interval_timer_three_counter_core test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(FUNC_READ, 2'd0, 8'h00, 16'h0);     // reads after reset
    send_beat(FUNC_READ, 2'd0, 8'h00, 16'h0);
    send_beat(FUNC_READ, PORT_CONTROL, 8'h00, 16'h0);
    send_beat(FUNC_WRITE, 2'd1, 8'hA5, 16'h0);    // data write with latch access code
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'hFFFF);
    send_beat(FUNC_NONE, 2'd2, 8'hFF, 16'hFFFF);  // unused func code
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'hFF, 16'h0); // counter 3 select is ignored
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'h30, 16'h0); // ctr0 both, one-shot
    send_beat(FUNC_WRITE, 2'd0, 8'h10, 16'h0);
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'h0005);
    send_beat(FUNC_WRITE, 2'd0, 8'h00, 16'h0);
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'h0011);
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'h76, 16'h0); // ctr1 both, square
    send_beat(FUNC_WRITE, 2'd1, 8'h02, 16'h0);          // reload 2 freezes
    send_beat(FUNC_WRITE, 2'd1, 8'h00, 16'h0);
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'h1234);
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'hBE, 16'h0);  // ctr2 both, mode 7
    send_beat(FUNC_WRITE, 2'd2, 8'hFF, 16'h0);
    send_beat(FUNC_WRITE, 2'd2, 8'hFF, 16'h0);
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'h8001);
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'h80, 16'h0);  // latch ctr2
    send_beat(FUNC_ADVANCE, 2'd0, 8'h00, 16'h0100);
    send_beat(FUNC_READ, 2'd2, 8'h00, 16'h0);
    send_beat(FUNC_READ, 2'd2, 8'h00, 16'h0);
    send_beat(FUNC_WRITE, PORT_CONTROL, 8'h64, 16'h0);  // ctr1 high only, mode 2
  endtask

  task automatic test_random();
    logic [1:0] f, p;
    logic [7:0] wd;
    logic [15:0] t;
    for (int i = 0; i < 1300; i++) begin
      if (i == 650) drain_results();
      f = ($urandom_range(0, 30) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
      p = 2'($urandom_range(0, 3));
      wd = 8'($urandom);
      if (f == FUNC_WRITE && p == PORT_CONTROL && $urandom_range(0, 1))
        wd[3:1] = $urandom_range(0, 1) ? MODE_SQUARE : MODE_ONESHOT;
      // Mostly small advances so that counts and edges are seen often.
      case ($urandom_range(0, 3))
        0: t = 16'($urandom);
        1: t = 16'($urandom_range(0, 300));
        default: t = 16'($urandom_range(0, 20));
      endcase
      send_beat(f, p, wd, t);
    end
  endtask

  initial begin
    timer_model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    drain_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("interval_timer_three_counter_core test passed");
    end else begin
      $display("interval_timer_three_counter_core test failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/itc_pkg.sv
design/itc_ctrl.sv
design/itc_div.sv
design/itc_dp.sv
design/interval_timer_three_counter_core.sv
sim/tb_top.sv
